@@ rtl/core/chts_pkg.sv @@
// Shared types and codes for the chained hash card set table.
// No dependencies; imported by every module of the block except chts_ram.
`timescale 1ns / 1ps

package chts_pkg;

	// command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_TEST   = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	// result status codes
	localparam logic [2:0] STS_ADDED   = 3'd0;
	localparam logic [2:0] STS_PRESENT = 3'd1;
	localparam logic [2:0] STS_FULL    = 3'd2;
	localparam logic [2:0] STS_HIT     = 3'd3;
	localparam logic [2:0] STS_MISS    = 3'd4;
	localparam logic [2:0] STS_NOROOM  = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic       latch;
		logic       sweep;
		logic       reset_regs;
		logic       head_load;
		logic       walk_read;
		logic       walk_cmp;
		logic       free_read;
		logic       alloc_free;
		logic       alloc_bump;
		logic       create;
		logic       slot_clr;
		logic       slot_read;
		logic       slot_next;
		logic       slot_store;
		logic       init_slot;
		logic       del_count;
		logic       unlink;
		logic       free_push;
		logic       emit;
		logic       emit_read;
		logic       emit_last;
		logic [2:0] emit_code;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       walk_end;
		logic       match;
		logic       free_avail;
		logic       bump_avail;
		logic       slot_valid;
		logic       slot_match;
		logic       slot_last;
		logic       sweep_done;
		logic       out_free;
	} dp_status_t;

endpackage

@@ rtl/core/chts_ram.sv @@
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module chts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/chts_datapath.sv @@
// Datapath: table memories, chain walk registers, allocator and counters.
// Depends on chts_pkg and chts_ram.
`timescale 1ns / 1ps

module chts_datapath
	import chts_pkg::*;
#(
	parameter int CAPACITY        = 256,
	parameter int CARDS_PER_ENTRY = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   ctl,
	output dp_status_t  st,
	input  logic [2:0]  command,
	input  logic [15:0] region,
	input  logic [15:0] card,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] card_value,
	output logic        card_valid,
	output logic        last,
	output logic [8:0]  entries_used,
	output logic [10:0] cards_used
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int IW  = AW + 1;
	localparam int SW  = (CARDS_PER_ENTRY > 1) ? $clog2(CARDS_PER_ENTRY) : 1;
	localparam int CAW = $clog2(CAPACITY * CARDS_PER_ENTRY);
	localparam int CW  = CAW + 1;
	localparam logic [IW-1:0] EMPTY = IW'(CAPACITY);

	logic [2:0]    cmd_q;
	logic [15:0]   region_q, card_q;
	logic [IW-1:0] head_q, cur_q, prev_q, steps_q, elink_q, free_q, bump_q, ec_q;
	logic [AW-1:0] e_q, clr_q;
	logic [CW-1:0] cc_q;
	logic [SW-1:0] slot_q;

	logic [IW-1:0]  bucket_rd, link_rd;
	logic [15:0]    region_rd;
	logic [16:0]    cards_rd;
	logic [AW-1:0]  hash;
	logic [CAW-1:0] caddr;
	logic           prev_empty;

	logic          bk_we, lk_we, cd_we;
	logic [AW-1:0] bk_waddr, lk_waddr, lk_raddr, bk_raddr;
	logic [IW-1:0] bk_wdata, lk_wdata;
	logic [16:0]   cd_wdata;

	assign hash       = region_q[AW-1:0];
	assign caddr      = CAW'(e_q * CARDS_PER_ENTRY) + CAW'(slot_q);
	assign prev_empty = prev_q >= EMPTY;

	// bucket heads
	assign bk_we    = ctl.sweep || ctl.create || (ctl.unlink && prev_empty);
	assign bk_waddr = ctl.sweep ? clr_q : hash;
	assign bk_wdata = ctl.sweep ? EMPTY : (ctl.create ? {1'b0, e_q} : elink_q);
	assign bk_raddr = region[AW-1:0];

	chts_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_bucket (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
		.re(ctl.latch), .raddr(bk_raddr), .rdata(bucket_rd)
	);

	chts_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_region (
		.clk(clk), .we(ctl.create), .waddr(e_q), .wdata(region_q),
		.re(ctl.walk_read), .raddr(cur_q[AW-1:0]), .rdata(region_rd)
	);

	// links: chain order and the free list share one store
	assign lk_we    = ctl.create || ctl.free_push || (ctl.unlink && !prev_empty);
	assign lk_waddr = ctl.unlink ? prev_q[AW-1:0] : e_q;
	assign lk_wdata = ctl.create ? head_q : (ctl.free_push ? free_q : elink_q);
	assign lk_raddr = ctl.free_read ? free_q[AW-1:0] : cur_q[AW-1:0];

	chts_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link (
		.clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
		.re(ctl.walk_read || ctl.free_read), .raddr(lk_raddr), .rdata(link_rd)
	);

	assign cd_we    = ctl.slot_store || ctl.init_slot;
	assign cd_wdata = (ctl.slot_store || slot_q == '0) ? {1'b1, card_q} : 17'd0;

	chts_ram #(.WIDTH(17), .DEPTH(CAPACITY * CARDS_PER_ENTRY)) u_cards (
		.clk(clk), .we(cd_we), .waddr(caddr), .wdata(cd_wdata),
		.re(ctl.slot_read), .raddr(caddr), .rdata(cards_rd)
	);

	// status
	assign st.cmd        = cmd_q;
	assign st.walk_end   = (cur_q >= EMPTY) || (steps_q == EMPTY);
	assign st.match      = region_rd == region_q;
	assign st.free_avail = free_q < EMPTY;
	assign st.bump_avail = ((IW+1)'(bump_q) + 1'b1) < (IW+1)'(CAPACITY);
	assign st.slot_valid = cards_rd[16];
	assign st.slot_match = cards_rd[15:0] == card_q;
	assign st.slot_last  = slot_q == SW'(CARDS_PER_ENTRY - 1);
	assign st.sweep_done = clr_q == AW'(CAPACITY - 1);
	assign st.out_free   = !out_valid || !out_stall;

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q    <= command;
			region_q <= region;
			card_q   <= card;
		end
		if (ctl.head_load) begin
			head_q  <= bucket_rd;
			cur_q   <= bucket_rd;
			prev_q  <= EMPTY;
			steps_q <= '0;
		end
		if (ctl.walk_cmp) begin
			if (region_rd == region_q) begin
				e_q     <= cur_q[AW-1:0];
				elink_q <= link_rd;
			end else begin
				prev_q  <= cur_q;
				cur_q   <= link_rd;
				steps_q <= steps_q + 1'b1;
			end
		end
		if (ctl.alloc_free) begin
			e_q <= free_q[AW-1:0];
		end
		if (ctl.alloc_bump) begin
			e_q <= bump_q[AW-1:0];
		end
		if (ctl.slot_clr) begin
			slot_q <= '0;
		end
		if (ctl.slot_next || ctl.init_slot) begin
			slot_q <= slot_q + 1'b1;
		end
		if (ctl.emit) begin
			status       <= ctl.emit_code;
			card_valid   <= ctl.emit_read && cards_rd[16];
			card_value   <= (ctl.emit_read && cards_rd[16]) ? cards_rd[15:0] : 16'd0;
			last         <= ctl.emit_last;
			entries_used <= 9'(ec_q);
			cards_used   <= 11'(cc_q);
		end
	end

	// control state: allocator, counters, sweep index, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q    <= EMPTY;
			bump_q    <= '0;
			ec_q      <= '0;
			cc_q      <= '0;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (ctl.sweep) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.reset_regs) begin
				free_q <= EMPTY;
				bump_q <= '0;
				ec_q   <= '0;
				cc_q   <= '0;
			end else begin
				if (ctl.alloc_free) begin
					free_q <= link_rd;
				end
				if (ctl.alloc_bump) begin
					bump_q <= bump_q + 1'b1;
				end
				if (ctl.create) begin
					ec_q <= ec_q + 1'b1;
				end
				if (ctl.free_push) begin
					free_q <= {1'b0, e_q};
					ec_q   <= ec_q - 1'b1;
				end
				if (ctl.slot_store || (ctl.init_slot && slot_q == '0)) begin
					cc_q <= cc_q + 1'b1;
				end
				if (ctl.del_count && cards_rd[16]) begin
					cc_q <= cc_q - 1'b1;
				end
			end
			if (ctl.emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/chts_ctrl.sv @@
// Controller state machine: sequences walks, allocation, slot scans and results.
// Depends on chts_pkg.
`timescale 1ns / 1ps

module chts_ctrl
	import chts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t st,
	output ctrl_cmd_t  ctl
);

	localparam logic [3:0] S_INIT      = 4'd0;
	localparam logic [3:0] S_IDLE      = 4'd1;
	localparam logic [3:0] S_HEAD      = 4'd2;
	localparam logic [3:0] S_WALK      = 4'd3;
	localparam logic [3:0] S_CMP       = 4'd4;
	localparam logic [3:0] S_DISP      = 4'd5;
	localparam logic [3:0] S_FREE_TAKE = 4'd6;
	localparam logic [3:0] S_CREATE    = 4'd7;
	localparam logic [3:0] S_INIT_SLOT = 4'd8;
	localparam logic [3:0] S_SLOT_RD   = 4'd9;
	localparam logic [3:0] S_SLOT_CHK  = 4'd10;
	localparam logic [3:0] S_UNLINK    = 4'd11;
	localparam logic [3:0] S_PUSH      = 4'd12;
	localparam logic [3:0] S_EMIT      = 4'd13;
	localparam logic [3:0] S_CLR       = 4'd14;

	logic [3:0] state_q, state_d;
	logic       found_q, found_d;
	logic [2:0] code_q, code_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		found_d = found_q;
		code_d  = code_q;
		ctl     = '0;
		unique case (state_q)
			S_INIT: begin
				ctl.sweep = 1'b1;
				if (st.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_HEAD;
				end
			end
			S_HEAD: begin
				if (st.cmd == CMD_CLEAR) begin
					state_d = S_CLR;
				end else if (st.cmd > CMD_CLEAR) begin
					code_d  = STS_MISS;
					state_d = S_EMIT;
				end else begin
					ctl.head_load = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_WALK: begin
				if (st.walk_end) begin
					found_d = 1'b0;
					state_d = S_DISP;
				end else begin
					ctl.walk_read = 1'b1;
					state_d       = S_CMP;
				end
			end
			S_CMP: begin
				ctl.walk_cmp = 1'b1;
				if (st.match) begin
					found_d = 1'b1;
					state_d = S_DISP;
				end else begin
					state_d = S_WALK;
				end
			end
			S_DISP: begin
				ctl.slot_clr = 1'b1;
				if (found_q) begin
					state_d = (st.cmd == CMD_DELETE) ? S_UNLINK : S_SLOT_RD;
				end else if (st.cmd != CMD_ADD) begin
					code_d  = STS_MISS;
					state_d = S_EMIT;
				end else if (st.free_avail) begin
					ctl.free_read = 1'b1;
					state_d       = S_FREE_TAKE;
				end else if (st.bump_avail) begin
					ctl.alloc_bump = 1'b1;
					state_d        = S_CREATE;
				end else begin
					code_d  = STS_NOROOM;
					state_d = S_EMIT;
				end
			end
			S_FREE_TAKE: begin
				ctl.alloc_free = 1'b1;
				state_d        = S_CREATE;
			end
			S_CREATE: begin
				ctl.create = 1'b1;
				state_d    = S_INIT_SLOT;
			end
			S_INIT_SLOT: begin
				// slot 0 takes the card, the rest are cleared
				ctl.init_slot = 1'b1;
				if (st.slot_last) begin
					code_d  = STS_ADDED;
					state_d = S_EMIT;
				end
			end
			S_SLOT_RD: begin
				ctl.slot_read = 1'b1;
				state_d       = S_SLOT_CHK;
			end
			S_SLOT_CHK: begin
				priority case (st.cmd)
					CMD_ADD: begin
						if (!st.slot_valid) begin
							ctl.slot_store = 1'b1;
							code_d         = STS_ADDED;
							state_d        = S_EMIT;
						end else if (st.slot_match) begin
							code_d  = STS_PRESENT;
							state_d = S_EMIT;
						end else if (st.slot_last) begin
							code_d  = STS_FULL;
							state_d = S_EMIT;
						end else begin
							ctl.slot_next = 1'b1;
							state_d       = S_SLOT_RD;
						end
					end
					CMD_TEST: begin
						if (st.slot_valid && st.slot_match) begin
							code_d  = STS_HIT;
							state_d = S_EMIT;
						end else if (st.slot_last) begin
							code_d  = STS_MISS;
							state_d = S_EMIT;
						end else begin
							ctl.slot_next = 1'b1;
							state_d       = S_SLOT_RD;
						end
					end
					CMD_DELETE: begin
						ctl.del_count = 1'b1;
						if (st.slot_last) begin
							state_d = S_PUSH;
						end else begin
							ctl.slot_next = 1'b1;
							state_d       = S_SLOT_RD;
						end
					end
					default: begin
						// read cards: one result per slot
						if (st.out_free) begin
							ctl.emit      = 1'b1;
							ctl.emit_read = 1'b1;
							ctl.emit_last = st.slot_last;
							ctl.emit_code = STS_HIT;
							if (st.slot_last) begin
								state_d = S_IDLE;
							end else begin
								ctl.slot_next = 1'b1;
								state_d       = S_SLOT_RD;
							end
						end
					end
				endcase
			end
			S_UNLINK: begin
				ctl.unlink = 1'b1;
				state_d    = S_SLOT_RD;
			end
			S_PUSH: begin
				ctl.free_push = 1'b1;
				code_d        = STS_HIT;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_last = 1'b1;
					ctl.emit_code = code_q;
					state_d       = S_IDLE;
				end
			end
			S_CLR: begin
				ctl.sweep = 1'b1;
				if (st.sweep_done) begin
					ctl.reset_regs = 1'b1;
					code_d         = STS_ADDED;
					state_d        = S_EMIT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			found_q <= 1'b0;
			code_q  <= STS_ADDED;
		end else begin
			state_q <= state_d;
			found_q <= found_d;
			code_q  <= code_d;
		end
	end

endmodule

@@ rtl/core/chained_hash_card_set_table_top.sv @@
// Chained hash table of card sets keyed by region number. Top level.
// Depends on chts_pkg, chts_ctrl, chts_datapath (and chts_ram below it).
`timescale 1ns / 1ps

// A region hashes to bucket region[log2(CAPACITY)-1:0]; each bucket heads a
// chain of entries linked by index, and each entry holds CARDS_PER_ENTRY card
// slots filled from slot 0 upward. Commands: add card, test card, delete
// region, read cards, clear. One command is in work at a time; in_stall is low
// only while the controller is idle, and a finished result sits in an output
// register so the next command is taken while it waits to be transferred.
// Each command is taken and its bucket head fetched, then for each chain
// entry visited the region/link stores are read and compared; a walk that
// misses then ends, and a dispatch step follows.
// Add/test/read/delete then scan card slots, a read and a check per slot;
// delete adds an unlink and a push onto the free list. A new entry is
// allocated from the bump pointer, or from the free list with an extra
// read, then linked, and its CARDS_PER_ENTRY slots are filled; a last step
// sends the result, except read cards, whose results leave straight from
// the slot scan. Output stalls make a command take longer.
// After reset and on every clear command a clearing pass writes the empty
// marker into all CAPACITY bucket heads, one per cycle; no command is taken
// during either pass. Read cards on a hit returns
// CARDS_PER_ENTRY results, last marking the final one; all other commands
// return one result. entries_used and cards_used reflect the state after the
// command. CAPACITY must be a power of two.

module chained_hash_card_set_table_top
	import chts_pkg::*;
#(
	parameter int CAPACITY        = 256,
	parameter int CARDS_PER_ENTRY = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [15:0] region,
	input  logic [15:0] card,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] card_value,
	output logic        card_valid,
	output logic        last,
	output logic [8:0]  entries_used,
	output logic [10:0] cards_used
);

	ctrl_cmd_t  ctl;
	dp_status_t st;

	// sequencing
	chts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.ctl      (ctl)
	);

	// storage, walk registers, counters and the result register
	chts_datapath #(
		.CAPACITY        (CAPACITY),
		.CARDS_PER_ENTRY (CARDS_PER_ENTRY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.st           (st),
		.command      (command),
		.region       (region),
		.card         (card),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.card_value   (card_value),
		.card_valid   (card_valid),
		.last         (last),
		.entries_used (entries_used),
		.cards_used   (cards_used)
	);

endmodule

@@ rtl/core/chts_checker.sv @@
// Port-level checks for the card set table, bound to the top level.
// Depends on chts_pkg and chained_hash_card_set_table_top.
`timescale 1ns / 1ps

module chts_checker
	import chts_pkg::*;
#(
	parameter int CAPACITY        = 256,
	parameter int CARDS_PER_ENTRY = 4
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] card_value,
	input logic        card_valid,
	input logic [8:0]  entries_used,
	input logic [10:0] cards_used
);

	// only read cards hits carry a slot
	a_valid_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && card_valid |-> status == STS_HIT)
		else $error("card_valid on a result that is not a hit");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !card_valid |-> card_value == 16'd0)
		else $error("card_value set without card_valid");

	// last slot is never handed out
	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(entries_used) < CAPACITY)
		else $error("entries_used beyond capacity");

	a_card_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cards_used) <= 32'(entries_used) * CARDS_PER_ENTRY)
		else $error("more cards than live entries can hold");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(cards_used))
		else $error("stalled result changed");

endmodule

bind chained_hash_card_set_table_top chts_checker #(
	.CAPACITY        (CAPACITY),
	.CARDS_PER_ENTRY (CARDS_PER_ENTRY)
) u_chts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.card_value   (card_value),
	.card_valid   (card_valid),
	.entries_used (entries_used),
	.cards_used   (cards_used)
);

@@ verif/tb.sv @@
// Self-checking testbench for chained_hash_card_set_table_top.
// Depends on chts_pkg and the block RTL; predicts every result in-line.
`timescale 1ns / 1ps

module tb
	import chts_pkg::*;
();

	localparam int CAP   = 256;
	localparam int SLOTS = 4;
	localparam int EMPTY = CAP;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] region;
		logic [15:0] card;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] card_value;
		logic        card_valid;
		logic        last;
		logic [8:0]  entries_used;
		logic [10:0] cards_used;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = '0;
	logic [15:0] region = '0;
	logic [15:0] card = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] card_value;
	logic        card_valid;
	logic        last;
	logic [8:0]  entries_used;
	logic [10:0] cards_used;

	chained_hash_card_set_table_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .region(region), .card(card),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .card_value(card_value), .card_valid(card_valid),
		.last(last), .entries_used(entries_used), .cards_used(cards_used)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow copy of the table, updated once per accepted command
	// ---------------------------------------------------------------
	int unsigned shadow_head [CAP];
	int unsigned shadow_region [CAP];
	int unsigned shadow_link [CAP];
	logic [16:0] shadow_cards [CAP*SLOTS];
	int unsigned shadow_free, shadow_bump, shadow_entries, shadow_card_cnt;

	cmd_item_t     pending_cmds[$];
	table_result_t expected_results[$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  hold_sender = 0;
	int  fail_count = 0;
	int  quiet_cycles = 0;
	bit  stim_done = 0;

	task automatic table_wipe();
		for (int i = 0; i < CAP; i++) shadow_head[i] = EMPTY;
		shadow_free = EMPTY;
		shadow_bump = 0;
		shadow_entries = 0;
		shadow_card_cnt = 0;
	endtask

	function automatic table_result_t mk_result(logic [2:0] st, logic [15:0] v,
			logic vl, logic lst);
		table_result_t r;
		r.status = st;
		r.card_value = v;
		r.card_valid = vl;
		r.last = lst;
		r.entries_used = shadow_entries[8:0];
		r.cards_used = shadow_card_cnt[10:0];
		return r;
	endfunction

	// chain walk: entry index or EMPTY, predecessor through prv
	function automatic int unsigned find_region(int unsigned rg, output int unsigned prv);
		int unsigned cur;
		int unsigned p;
		int unsigned steps;
		cur = shadow_head[rg % CAP];
		p = EMPTY;
		steps = 0;
		prv = EMPTY;
		while (cur < CAP && steps < CAP) begin
			if (shadow_region[cur] == rg) begin
				prv = p;
				return cur;
			end
			p = cur;
			cur = shadow_link[cur];
			steps++;
		end
		return EMPTY;
	endfunction

	task automatic predict_command(cmd_item_t it);
		int unsigned e;
		int unsigned prv;
		int unsigned b;
		bit done;
		e = find_region(it.region, prv);
		b = it.region % CAP;
		done = 0;
		case (it.command)
			CMD_ADD: begin
				if (e >= CAP) begin
					if (shadow_free < CAP) begin
						e = shadow_free;
						shadow_free = shadow_link[e];
					end else if (shadow_bump + 1 < CAP) begin
						e = shadow_bump;
						shadow_bump++;
					end else begin
						expected_results.push_back(
							mk_result(STS_NOROOM, 16'd0, 1'b0, 1'b1));
						return;
					end
					shadow_region[e] = it.region;
					for (int i = 0; i < SLOTS; i++) shadow_cards[e*SLOTS+i] = '0;
					shadow_link[e] = shadow_head[b];
					shadow_head[b] = e;
					shadow_entries++;
				end
				for (int i = 0; i < SLOTS && !done; i++) begin
					if (!shadow_cards[e*SLOTS+i][16]) begin
						shadow_cards[e*SLOTS+i] = {1'b1, it.card};
						shadow_card_cnt++;
						expected_results.push_back(mk_result(STS_ADDED, 16'd0, 1'b0, 1'b1));
						done = 1;
					end else if (shadow_cards[e*SLOTS+i][15:0] == it.card) begin
						expected_results.push_back(
							mk_result(STS_PRESENT, 16'd0, 1'b0, 1'b1));
						done = 1;
					end
				end
				if (!done)
					expected_results.push_back(mk_result(STS_FULL, 16'd0, 1'b0, 1'b1));
			end
			CMD_TEST: begin
				if (e < CAP)
					for (int i = 0; i < SLOTS; i++)
						if (shadow_cards[e*SLOTS+i] == {1'b1, it.card}) done = 1;
				expected_results.push_back(
					mk_result(done ? STS_HIT : STS_MISS, 16'd0, 1'b0, 1'b1));
			end
			CMD_DELETE: begin
				if (e >= CAP) begin
					expected_results.push_back(mk_result(STS_MISS, 16'd0, 1'b0, 1'b1));
				end else begin
					if (prv < CAP) shadow_link[prv] = shadow_link[e];
					else shadow_head[b] = shadow_link[e];
					for (int i = 0; i < SLOTS; i++)
						if (shadow_cards[e*SLOTS+i][16]) shadow_card_cnt--;
					shadow_link[e] = shadow_free;
					shadow_free = e;
					shadow_entries--;
					expected_results.push_back(mk_result(STS_HIT, 16'd0, 1'b0, 1'b1));
				end
			end
			CMD_READ: begin
				if (e >= CAP) begin
					expected_results.push_back(mk_result(STS_MISS, 16'd0, 1'b0, 1'b1));
				end else begin
					for (int i = 0; i < SLOTS; i++) begin
						logic [16:0] c;
						c = shadow_cards[e*SLOTS+i];
						expected_results.push_back(mk_result(STS_HIT,
							c[16] ? c[15:0] : 16'd0, c[16], i == SLOTS-1));
					end
				end
			end
			CMD_CLEAR: begin
				table_wipe();
				expected_results.push_back(mk_result(STS_ADDED, 16'd0, 1'b0, 1'b1));
			end
			default: expected_results.push_back(mk_result(STS_MISS, 16'd0, 1'b0, 1'b1));
		endcase
	endtask

	// ---------------------------------------------------------------
	// Driver: presents queued commands; payload held while stalled
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_command({command, region, card});
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() > 0 && !hold_sender &&
						$urandom_range(99) >= send_idle_pct) begin
					cmd_item_t it;
					it = pending_cmds.pop_front();
					in_valid <= 1'b1;
					command <= it.command;
					region <= it.region;
					card <= it.card;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compare each result transfer with the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				quiet_cycles <= 0;
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					table_result_t x;
					x = expected_results.pop_front();
					if (status !== x.status) begin
						$error("status exp %0d got %0d", x.status, status); fail_count++;
					end
					if (card_value !== x.card_value) begin
						$error("card_value exp %0h got %0h", x.card_value, card_value);
						fail_count++;
					end
					if (card_valid !== x.card_valid) begin
						$error("card_valid exp %0d got %0d", x.card_valid, card_valid);
						fail_count++;
					end
					if (last !== x.last) begin
						$error("last exp %0d got %0d", x.last, last); fail_count++;
					end
					if (entries_used !== x.entries_used) begin
						$error("entries_used exp %0d got %0d", x.entries_used, entries_used);
						fail_count++;
					end
					if (cards_used !== x.cards_used) begin
						$error("cards_used exp %0d got %0d", x.cards_used, cards_used);
						fail_count++;
					end
				end
			end else if (in_valid && !in_stall) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			// clear passes after reset run with nothing moving
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic cmd_item_t mk_cmd(logic [2:0] c, logic [15:0] r, logic [15:0] k);
		cmd_item_t it;
		it.command = c;
		it.region = r;
		it.card = k;
		return it;
	endfunction

	// random traffic mostly around a small pool of regions so chains form
	task automatic queue_random(int n);
		logic [15:0] rg;
		logic [15:0] cd;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if ($urandom_range(3) == 0) rg = 16'($urandom);
			else rg = 16'(($urandom_range(7) << 8) | $urandom_range(3));
			cd = ($urandom_range(1) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
			if (sel < 45)      pending_cmds.push_back(mk_cmd(CMD_ADD, rg, cd));
			else if (sel < 62) pending_cmds.push_back(mk_cmd(CMD_TEST, rg, cd));
			else if (sel < 75) pending_cmds.push_back(mk_cmd(CMD_DELETE, rg, cd));
			else if (sel < 95) pending_cmds.push_back(mk_cmd(CMD_READ, rg, cd));
			else if (sel < 97) pending_cmds.push_back(mk_cmd(CMD_CLEAR, rg, cd));
			else pending_cmds.push_back(mk_cmd(3'($urandom_range(7, 5)), rg, cd));
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		table_wipe();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every command, slot-full, duplicates, misses
		send_idle_pct = 22;
		recv_idle_pct = 61;
		pending_cmds.push_back(mk_cmd(CMD_READ, 16'h0000, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'h0000, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'h0000, 16'hFFFF));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'h0000, 16'hFFFF));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'h0000, 16'h5555));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'h0000, 16'hAAAA));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'h0000, 16'h1234));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'hFF00, 16'h0001));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF));
		pending_cmds.push_back(mk_cmd(CMD_TEST, 16'h0000, 16'hAAAA));
		pending_cmds.push_back(mk_cmd(CMD_TEST, 16'h0000, 16'h1234));
		pending_cmds.push_back(mk_cmd(CMD_TEST, 16'h0100, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_READ, 16'h0000, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_READ, 16'hFF00, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_DELETE, 16'h0000, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_DELETE, 16'h0000, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'h0100, 16'h0007));
		pending_cmds.push_back(mk_cmd(CMD_READ, 16'hFF00, 16'h0000));
		pending_cmds.push_back(mk_cmd(3'd5, 16'hFFFF, 16'hFFFF));
		pending_cmds.push_back(mk_cmd(3'd7, 16'h0000, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_CLEAR, 16'h0000, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_TEST, 16'hFFFF, 16'hFFFF));
		wait_drained();

		// hold-off: sender pauses with the block fully drained
		send_idle_pct = 61;
		recv_idle_pct = 22;
		hold_sender = 1;
		queue_random(16);
		repeat (20) @(posedge clk);
		hold_sender = 0;
		wait_drained();

		// fill the table: 255 entries, then table-full, then reuse a freed slot
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < CAP; i++)
			pending_cmds.push_back(mk_cmd(CMD_ADD, 16'(i * 3 + 16'h2000), 16'(i)));
		pending_cmds.push_back(mk_cmd(CMD_DELETE, 16'h2003, 16'h0000));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'hBEEF, 16'h0042));
		pending_cmds.push_back(mk_cmd(CMD_ADD, 16'hBEF0, 16'h0042));
		pending_cmds.push_back(mk_cmd(CMD_CLEAR, 16'h0000, 16'h0000));
		wait_drained();
		repeat (40) @(posedge clk);

		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
